### src/fdn4_pkg.sv
// fdn4_pkg: shared types, constants and saturation helpers for the fdn4 reverb core
// no dependencies; imported by every other file of the block

package fdn4_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int ACC_W     = 28;
    localparam int CFG_W     = 32;
    localparam int WET_W     = 16;
    localparam int WIDE_W    = 48;
    localparam int NUM_LINES = 4;
    localparam int NUM_REGS  = 5;
    localparam int ADDR_W    = $clog2(4 * NUM_REGS);

    // default delay line lengths in samples
    localparam int LEN0_DEF = 1492;
    localparam int LEN1_DEF = 1809;
    localparam int LEN2_DEF = 2011;
    localparam int LEN3_DEF = 2558;

    // result buffer and outstanding request count
    localparam int OBUF_DEPTH = 3;
    localparam int PEND_W     = $clog2(OBUF_DEPTH + 1);

    // q15 scaling
    localparam int Q_FRAC   = 15;
    localparam int RND_HALF = 1 << (Q_FRAC - 1);
    localparam logic [WET_W-1:0] FULL_WET = WET_W'(1 << Q_FRAC);

    typedef logic signed [SAMPLE_W-1:0] t_smp;
    typedef logic signed [ACC_W-1:0]    t_acc;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam t_smp SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_smp SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // register map
    typedef enum logic [ADDR_W-3:0] {
        REG_LINE0 = 3'd0,
        REG_LINE1 = 3'd1,
        REG_LINE2 = 3'd2,
        REG_LINE3 = 3'd3,
        REG_WET   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_LINES-1:0][CFG_W-1:0] coefs;
        logic [WET_W-1:0]                wet_gain;
    } t_cfg;

    typedef struct packed {
        t_smp out_left;
        t_smp out_right;
        logic frame_end_out;
    } t_out_item;

    // saturate a wide value to the internal 28-bit range
    function automatic t_acc f_sat_acc(input logic signed [WIDE_W-1:0] v);
        if (v > WIDE_W'(ACC_MAX)) begin
            return ACC_MAX;
        end else if (v < WIDE_W'(ACC_MIN)) begin
            return ACC_MIN;
        end
        return t_acc'(v[ACC_W-1:0]);
    endfunction

    // saturate a wide value to the 24-bit sample range
    function automatic t_smp f_sat_smp(input logic signed [WIDE_W-1:0] v);
        if (v > WIDE_W'(SMP_MAX)) begin
            return SMP_MAX;
        end else if (v < WIDE_W'(SMP_MIN)) begin
            return SMP_MIN;
        end
        return t_smp'(v[SAMPLE_W-1:0]);
    endfunction

endpackage

### src/fdn4_if.sv
// fdn4_if: valid/ready stream interfaces for input and result requests
// depends on fdn4_pkg for the sample type

interface fdn4_in_if import fdn4_pkg::*; ;
    logic valid;
    logic ready;
    t_smp in_left;
    t_smp in_right;
    logic frame_end;

    modport source (output valid, output in_left, output in_right, output frame_end,
                    input ready);
    modport sink   (input valid, input in_left, input in_right, input frame_end,
                    output ready);
endinterface

interface fdn4_out_if import fdn4_pkg::*; ;
    logic valid;
    logic ready;
    t_smp out_left;
    t_smp out_right;
    logic frame_end_out;

    modport source (output valid, output out_left, output out_right, output frame_end_out,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input frame_end_out,
                    output ready);
endinterface

### src/fdn4_regs.sv
// fdn4_regs: apb register file holding filter coefficients and wet gain
// depends on fdn4_pkg for the register map and config struct

module fdn4_regs import fdn4_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (idx)
                REG_LINE0: r_cfg.coefs[0] <= pwdata;
                REG_LINE1: r_cfg.coefs[1] <= pwdata;
                REG_LINE2: r_cfg.coefs[2] <= pwdata;
                REG_LINE3: r_cfg.coefs[3] <= pwdata;
                REG_WET:   r_cfg.wet_gain <= pwdata[WET_W-1:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_LINE0: prdata = r_cfg.coefs[0];
            REG_LINE1: prdata = r_cfg.coefs[1];
            REG_LINE2: prdata = r_cfg.coefs[2];
            REG_LINE3: prdata = r_cfg.coefs[3];
            REG_WET:   prdata = {{(CFG_W-WET_W){1'b0}}, r_cfg.wet_gain};
            default:   prdata = '0;
        endcase
    end

endmodule

### src/fdn4_line.sv
// fdn4_line: one circular delay line in a synchronous memory with its pointer
// depends on fdn4_pkg; a lap flag makes never-written entries read as zero

module fdn4_line import fdn4_pkg::*; #(
    parameter int LEN = LEN0_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rd_en,
    input  logic i_wr_en,
    input  t_acc i_wr_data,
    output t_acc o_rd_data
);

    localparam int AW = (LEN > 1) ? $clog2(LEN) : 1;
    localparam logic [AW-1:0] LAST = AW'(LEN - 1);

    t_acc            r_mem [LEN];
    t_acc            r_raw;
    t_acc            r_fwd_data;
    logic [AW-1:0]   r_ptr;
    logic [AW-1:0]   r_wa;
    logic [AW-1:0]   n_ptr;
    logic            r_lap;
    logic            r_hit;
    logic            r_fwd;

    assign n_ptr = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;

    // pointer, lap flag and read qualifiers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_wa  <= '0;
            r_lap <= 1'b0;
            r_hit <= 1'b0;
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_ptr <= n_ptr;
            r_wa  <= r_ptr;
            r_hit <= r_lap;
            r_fwd <= i_wr_en && (r_ptr == r_wa);
            if (r_ptr == LAST) begin
                r_lap <= 1'b1;
            end
        end
    end

    // memory: write back at the slot read last, registered read at the pointer
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wa] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_raw <= r_mem[r_ptr];
        end
    end

    // write data captured for a read of the same slot in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_hit ? r_raw : '0);

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST)
        else $error("delay pointer beyond line length");

    a_fwd_len1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (LEN == 1))
        else $error("same-slot forward on a line longer than one");

endmodule

### src/fdn4_obuf.sv
// fdn4_obuf: small result buffer that drives the output stream
// depends on fdn4_pkg and fdn4_out_if

module fdn4_obuf import fdn4_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_out_item  i_item,
    fdn4_out_if.source o_out
);

    localparam int PW = (OBUF_DEPTH > 1) ? $clog2(OBUF_DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(OBUF_DEPTH - 1);

    t_out_item         r_mem [OBUF_DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [PEND_W-1:0] r_cnt;
    logic              pop;

    assign o_out.valid = (r_cnt != '0);
    assign pop         = o_out.valid && o_out.ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_out.out_left      = r_mem[r_rd].out_left;
    assign o_out.out_right     = r_mem[r_rd].out_right;
    assign o_out.frame_end_out = r_mem[r_rd].frame_end_out;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != PEND_W'(OBUF_DEPTH)))
        else $error("result buffer overflow");

endmodule

### src/fdn4_reverb_core.sv
// fdn4_reverb_core: four-line feedback delay network reverb, top level
// depends on fdn4_pkg, fdn4_if, fdn4_regs, fdn4_line and fdn4_obuf

// Each stereo request gives one stereo result. A new request is taken before
// earlier ones finish, but not while stage 1 holds one, as the absorption
// filter of each line multiplies the previous line output and the previous
// filter output, then adds, rounds and saturates in the next cycle, and the
// next request needs that result. Each delay line is a synchronous memory
// read once and written once per request; a same-slot write is forwarded to
// the read. Memories need no clearing pass after reset: a per-line lap flag
// returns zero for entries not yet written. Results wait in a three-entry
// buffer, so new requests are taken while the output is stalled until three
// results are outstanding. The user must write coefficients and wet gain
// over APB only while no request is in flight; the block does not check it.

module fdn4_reverb_core import fdn4_pkg::*; #(
    parameter int LEN0 = LEN0_DEF,
    parameter int LEN1 = LEN1_DEF,
    parameter int LEN2 = LEN2_DEF,
    parameter int LEN3 = LEN3_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fdn4_in_if.sink           i_in,
    fdn4_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    t_cfg              cfg;
    logic              in_ok;
    logic              out_ok;
    logic [PEND_W-1:0] r_pend;
    logic [WET_W-1:0]  wet_c;
    logic [WET_W-1:0]  dry_c;

    // pipeline control
    logic r_s1_v, r_s2_v, r_s3_v;

    // stage payloads
    t_smp r_s1_l, r_s1_r, r_s2_l, r_s2_r;
    logic r_s1_fe, r_s2_fe, r_s3_fe;
    t_smp r_s3_mono;

    // line and filter state
    t_acc line_out [NUM_LINES];
    t_acc feed     [NUM_LINES];
    t_acc absorbed [NUM_LINES];
    t_acc r_hist   [NUM_LINES];

    // absorption products
    logic signed [44:0] pb   [NUM_LINES];
    logic signed [43:0] pa   [NUM_LINES];
    logic signed [44:0] r_pb [NUM_LINES];
    logic signed [43:0] r_pa [NUM_LINES];

    // output mix products
    logic signed [28:0] diff_l, diff_r;
    logic signed [45:0] pwl, pwr, r_pwl, r_pwr;
    logic signed [40:0] pdl, pdr, r_pdl, r_pdr;
    t_smp               mono;
    logic signed [29:0] had [NUM_LINES];
    logic signed [46:0] osum_l, osum_r;
    t_out_item          res;

    fdn4_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // wet gain clamped to full scale
    assign wet_c = (cfg.wet_gain > FULL_WET) ? FULL_WET : cfg.wet_gain;
    assign dry_c = FULL_WET - wet_c;

    // handshakes
    assign i_in.ready = !r_s1_v && (r_pend < PEND_W'(OBUF_DEPTH));
    assign in_ok      = i_in.valid && i_in.ready;
    assign out_ok     = o_out.valid && o_out.ready;

    // stage valids and outstanding request count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_pend <= '0;
        end else begin
            r_s1_v <= in_ok;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            case ({in_ok, out_ok})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    // capture the request
    always_ff @(posedge i_clk) begin
        if (in_ok) begin
            r_s1_l  <= i_in.in_left;
            r_s1_r  <= i_in.in_right;
            r_s1_fe <= i_in.frame_end;
        end
    end

    // delay lines: read in stage 1, write back in stage 3
    fdn4_line #(.LEN(LEN0)) u_line0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_en(r_s1_v), .i_wr_en(r_s3_v),
        .i_wr_data(feed[0]), .o_rd_data(line_out[0])
    );
    fdn4_line #(.LEN(LEN1)) u_line1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_en(r_s1_v), .i_wr_en(r_s3_v),
        .i_wr_data(feed[1]), .o_rd_data(line_out[1])
    );
    fdn4_line #(.LEN(LEN2)) u_line2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_en(r_s1_v), .i_wr_en(r_s3_v),
        .i_wr_data(feed[2]), .o_rd_data(line_out[2])
    );
    fdn4_line #(.LEN(LEN3)) u_line3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_en(r_s1_v), .i_wr_en(r_s3_v),
        .i_wr_data(feed[3]), .o_rd_data(line_out[3])
    );

    // stage 1: absorption filter products from the previous line outputs
    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            pb[k] = 45'($signed({1'b0, cfg.coefs[k][CFG_W-1:16]}) * line_out[k]);
            pa[k] = 44'($signed(cfg.coefs[k][15:0]) * r_hist[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                r_pb[k] <= pb[k];
                r_pa[k] <= pa[k];
            end
            r_s2_l  <= r_s1_l;
            r_s2_r  <= r_s1_r;
            r_s2_fe <= r_s1_fe;
        end
    end

    // stage 2: filter sum, round and saturate
    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            absorbed[k] = f_sat_acc(WIDE_W'((47'(r_pb[k]) + 47'(r_pa[k])
                                             + 47'(RND_HALF)) >>> Q_FRAC));
        end
    end

    // stage 2: dry/wet products against the fresh line outputs
    assign diff_l = 29'(line_out[0]) - 29'(line_out[2]);
    assign diff_r = 29'(line_out[1]) - 29'(line_out[3]);
    assign pwl    = 46'($signed({1'b0, wet_c}) * diff_l);
    assign pwr    = 46'($signed({1'b0, wet_c}) * diff_r);
    assign pdl    = 41'($signed({1'b0, dry_c}) * r_s2_l);
    assign pdr    = 41'($signed({1'b0, dry_c}) * r_s2_r);
    assign mono   = t_smp'((25'(r_s2_l) + 25'(r_s2_r)) >>> 1);

    // filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                r_hist[k] <= '0;
            end
        end else if (r_s2_v) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                r_hist[k] <= absorbed[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_pwl     <= pwl;
            r_pwr     <= pwr;
            r_pdl     <= pdl;
            r_pdr     <= pdr;
            r_s3_mono <= mono;
            r_s3_fe   <= r_s2_fe;
        end
    end

    // stage 3: hadamard mix and feedback
    assign had[0] = 30'(r_hist[0]) + 30'(r_hist[1]) + 30'(r_hist[2]) + 30'(r_hist[3]);
    assign had[1] = 30'(r_hist[0]) - 30'(r_hist[1]) + 30'(r_hist[2]) - 30'(r_hist[3]);
    assign had[2] = 30'(r_hist[0]) + 30'(r_hist[1]) - 30'(r_hist[2]) - 30'(r_hist[3]);
    assign had[3] = 30'(r_hist[0]) - 30'(r_hist[1]) - 30'(r_hist[2]) + 30'(r_hist[3]);

    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            feed[k] = f_sat_acc(WIDE_W'(30'(r_s3_mono) + (had[k] >>> 1)));
        end
    end

    // stage 3: output blend, round and saturate
    assign osum_l = 47'(r_pdl) + 47'(r_pwl) + 47'(RND_HALF);
    assign osum_r = 47'(r_pdr) + 47'(r_pwr) + 47'(RND_HALF);

    always_comb begin
        res.out_left      = f_sat_smp(WIDE_W'(osum_l >>> Q_FRAC));
        res.out_right     = f_sat_smp(WIDE_W'(osum_r >>> Q_FRAC));
        res.frame_end_out = r_s3_fe;
    end

    fdn4_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_v),
        .i_item  (res),
        .o_out   (o_out)
    );

    a_loop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_v && r_s2_v))
        else $error("two requests inside the filter loop");

    a_result_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_pend != '0))
        else $error("result shown with no request outstanding");

    a_push_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> (r_pend != '0))
        else $error("result produced with no request outstanding");

endmodule

### sim/tb_fdn4_reverb_core.sv
`timescale 1ns / 100ps
// tb_fdn4_reverb_core: self-checking testbench for the four-line fdn reverb core
// depends on fdn4_pkg, fdn4_if and the core rtl; predicts every output request in place

module tb_fdn4_reverb_core import fdn4_pkg::*; ;

    localparam int CLK_HALF       = 10;
    localparam int RST_CYCLES     = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int MAX_LEN        = LEN3_DEF;

    localparam longint ACC_HI = ACC_MAX;
    localparam longint ACC_LO = ACC_MIN;
    localparam longint SMP_HI = SMP_MAX;
    localparam longint SMP_LO = SMP_MIN;

    // coefficient sets used across the random phases
    typedef enum int {
        SET_MODERATE,
        SET_SATURATE,
        SET_WILD,
        SET_DECAY
    } t_coef_set;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    fdn4_in_if  in_bus ();
    fdn4_out_if out_bus ();

    fdn4_reverb_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of registers and network state
    logic [CFG_W-1:0] coef_reg [NUM_LINES];
    logic [WET_W-1:0] wet_reg;
    longint           line_mem [NUM_LINES][MAX_LEN];
    int               line_len [NUM_LINES];
    int               wr_ptr [NUM_LINES];
    longint           tap_val [NUM_LINES];
    longint           absorb_val [NUM_LINES];
    t_out_item        reverb_out_q [$];

    int error_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;
    int hold_left;
    int stuck_cycles;

    // clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    function automatic longint clamp_val(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // round half up, then floor to q15
    function automatic longint round_q15(longint v);
        return (v + RND_HALF) >>> Q_FRAC;
    endfunction

    function automatic void clear_reverb_state();
        int k;
        int i;
        line_len = '{LEN0_DEF, LEN1_DEF, LEN2_DEF, LEN3_DEF};
        wet_reg = '0;
        for (k = 0; k < NUM_LINES; k++) begin
            coef_reg[k]   = '0;
            wr_ptr[k]     = 0;
            tap_val[k]    = 0;
            absorb_val[k] = 0;
            for (i = 0; i < MAX_LEN; i++) begin
                line_mem[k][i] = 0;
            end
        end
    endfunction

    // one network step: absorption, hadamard feedback, delay lines, dry/wet blend
    function automatic t_out_item predict_reverb_out(t_smp l_in, t_smp r_in, logic fe);
        longint l;
        longint r;
        longint mono;
        longint b0;
        longint a1;
        longint wet;
        longint dry;
        longint ab [NUM_LINES];
        longint hs [NUM_LINES];
        longint fb [NUM_LINES];
        int k;
        t_out_item res;
        l = l_in;
        r = r_in;
        mono = (l + r) >>> 1;
        for (k = 0; k < NUM_LINES; k++) begin
            b0 = longint'(coef_reg[k][31:16]);
            a1 = longint'($signed(coef_reg[k][15:0]));
            ab[k] = clamp_val(round_q15(b0 * tap_val[k] + a1 * absorb_val[k]), ACC_LO, ACC_HI);
            absorb_val[k] = ab[k];
        end
        hs[0] = ab[0] + ab[1] + ab[2] + ab[3];
        hs[1] = ab[0] - ab[1] + ab[2] - ab[3];
        hs[2] = ab[0] + ab[1] - ab[2] - ab[3];
        hs[3] = ab[0] - ab[1] - ab[2] + ab[3];
        for (k = 0; k < NUM_LINES; k++) begin
            fb[k] = clamp_val(mono + (hs[k] >>> 1), ACC_LO, ACC_HI);
        end
        // read the oldest sample, then overwrite it with the new feed
        for (k = 0; k < NUM_LINES; k++) begin
            if (wr_ptr[k] >= line_len[k]) begin
                wr_ptr[k] = 0;
            end
            tap_val[k] = line_mem[k][wr_ptr[k]];
            line_mem[k][wr_ptr[k]] = fb[k];
            wr_ptr[k] = (wr_ptr[k] + 1 >= line_len[k]) ? 0 : wr_ptr[k] + 1;
        end
        wet = (wet_reg > FULL_WET) ? longint'(FULL_WET) : longint'(wet_reg);
        dry = longint'(FULL_WET) - wet;
        res.out_left = t_smp'(clamp_val(round_q15(dry * l + wet * (tap_val[0] - tap_val[2])),
                                        SMP_LO, SMP_HI));
        res.out_right = t_smp'(clamp_val(round_q15(dry * r + wet * (tap_val[1] - tap_val[3])),
                                         SMP_LO, SMP_HI));
        res.frame_end_out = fe;
        return res;
    endfunction

    // apb write: setup phase, access phase, then idle before returning
    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WET) begin
            wet_reg = value[WET_W-1:0];
        end else begin
            coef_reg[idx] = value;
        end
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(logic [CFG_W-1:0] c0, logic [CFG_W-1:0] c1,
                                  logic [CFG_W-1:0] c2, logic [CFG_W-1:0] c3,
                                  logic [WET_W-1:0] wet);
        write_reg(REG_LINE0, c0);
        write_reg(REG_LINE1, c1);
        write_reg(REG_LINE2, c2);
        write_reg(REG_LINE3, c3);
        write_reg(REG_WET, CFG_W'(wet));
    endtask

    // offer one request, idling at random first; predicts on acceptance
    task automatic send_request(t_smp l, t_smp r, logic fe);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.in_left   <= l;
        in_bus.in_right  <= r;
        in_bus.frame_end <= fe;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        reverb_out_q.push_back(predict_reverb_out(l, r, fe));
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_results_drained();
        in_bus.valid <= 1'b0;
        while (reverb_out_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_smp pick_sample();
        case ($urandom_range(9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return t_smp'(int'($urandom_range(4095)) - 2048);
            default: return t_smp'($urandom);
        endcase
    endfunction

    task automatic apply_coef_set(t_coef_set kind);
        case (kind)
            SET_MODERATE: begin
                write_all_regs({16'($urandom_range(16'hFFFF, 16'h4000)), 16'($urandom)},
                               {16'($urandom_range(16'hFFFF, 16'h4000)), 16'($urandom)},
                               {16'($urandom_range(16'hFFFF, 16'h4000)), 16'($urandom)},
                               {16'($urandom_range(16'hFFFF, 16'h4000)), 16'($urandom)},
                               16'($urandom_range(32768)));
            end
            SET_SATURATE: begin
                write_all_regs(32'hFFFF_7FFF, 32'hFFFF_8000, 32'h0000_7FFF, 32'hFFFF_0000,
                               FULL_WET);
            end
            SET_WILD: begin
                write_all_regs($urandom, $urandom, $urandom, $urandom, 16'hFFFF);
            end
            default: begin
                write_all_regs({16'($urandom_range(16'h3FFF)), 16'($urandom)},
                               {16'($urandom_range(16'h3FFF)), 16'($urandom)},
                               {16'($urandom_range(16'h3FFF)), 16'($urandom)},
                               {16'($urandom_range(16'h3FFF)), 16'($urandom)},
                               16'($urandom));
            end
        endcase
    endtask

    // full-scale and sign corner samples under reset, over-range wet and mixed settings
    task automatic test_directed_edges();
        int pass;
        for (pass = 0; pass < 3; pass++) begin
            wait_results_drained();
            if (pass == 1) begin
                write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               16'h8001);
            end else if (pass == 2) begin
                write_all_regs(32'hFFFF_7FFF, 32'h8000_8000, 32'h0001_0001, 32'h0000_0000,
                               16'h4000);
            end
            send_request(t_smp'(0), t_smp'(0), 1'b0);
            send_request(SMP_MAX, SMP_MAX, 1'b1);
            send_request(SMP_MIN, SMP_MIN, 1'b0);
            send_request(SMP_MAX, SMP_MIN, 1'b1);
            send_request(SMP_MIN, SMP_MAX, 1'b0);
            send_request(t_smp'(-1), t_smp'(0), 1'b1);
            send_request(t_smp'(1), t_smp'(-2), 1'b0);
        end
    endtask

    // random stereo stream under one coefficient set and idle mix
    task automatic test_random_stream(t_coef_set kind, int n, int tx_pct, int rx_pct);
        t_smp l;
        t_smp r;
        int i;
        wait_results_drained();
        apply_coef_set(kind);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (i = 0; i < n; i++) begin
            l = pick_sample();
            r = ($urandom_range(3) == 0) ? l : pick_sample();
            send_request(l, r, ($urandom_range(7) == 0));
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        int saved_tx;
        int i;
        saved_tx = tx_idle_pct;
        tx_idle_pct = 0;
        hold_request = 1'b1;
        for (i = 0; i < 60; i++) begin
            send_request(pick_sample(), pick_sample(), ($urandom_range(7) == 0));
        end
        tx_idle_pct = saved_tx;
    endtask

    // result receiver with random stalls and a counted hold-off
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (reverb_out_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected result: L=%0d R=%0d F=%0b", out_bus.out_left,
                             out_bus.out_right, out_bus.frame_end_out);
                end
            end else begin
                want = reverb_out_q.pop_front();
                if (out_bus.out_left !== want.out_left || out_bus.out_right !== want.out_right
                    || out_bus.frame_end_out !== want.frame_end_out) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch: expected L=%0d R=%0d F=%0b, got L=%0d R=%0d F=%0b",
                                 want.out_left, want.out_right, want.frame_end_out,
                                 out_bus.out_left, out_bus.out_right, out_bus.frame_end_out);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request moving either way
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
            || (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_bus.valid     <= 1'b0;
        in_bus.in_left   <= '0;
        in_bus.in_right  <= '0;
        in_bus.frame_end <= 1'b0;
        error_count  = 0;
        stuck_cycles = 0;
        hold_request = 1'b0;
        hold_left    = 0;
        tx_idle_pct  = 28;
        rx_idle_pct  = 64;
        clear_reverb_state();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_random_stream(SET_MODERATE, 600, 28, 64);
        test_output_backpressure();
        test_random_stream(SET_SATURATE, 600, 64, 28);
        test_random_stream(SET_WILD, 350, 0, 0);
        test_random_stream(SET_DECAY, 400, 0, 0);
        wait_results_drained();

        if (error_count == 0 && reverb_out_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
src/fdn4_pkg.sv
src/fdn4_if.sv
src/fdn4_regs.sv
src/fdn4_line.sv
src/fdn4_obuf.sv
src/fdn4_reverb_core.sv
sim/tb_fdn4_reverb_core.sv
